@@ sv/obb_to_aabb_assert.svh @@
// assertion macros for the obb_to_aabb block
`ifndef OBB_TO_AABB_ASSERT_SVH
`define OBB_TO_AABB_ASSERT_SVH

`ifndef SYNTHESIS

// pre holds at an edge, post holds at the same edge
`define OBB_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("obb_to_aabb assertion failed");

// pre holds at an edge, post holds after a delay given by the n argument
`define OBB_ASSERT_DLY(label, clk, rst_n, pre, n, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##n (post)) \
        else $error("obb_to_aabb assertion failed");

`else

`define OBB_ASSERT_IMP(label, clk, rst_n, pre, post)
`define OBB_ASSERT_DLY(label, clk, rst_n, pre, n, post)

`endif

`endif

@@ sv/obb_pkg.sv @@
`timescale 1ns / 1ps

package obb_pkg;

    localparam int COORD_BITS     = 32;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int QUAT_W         = QUAT_FRAC_BITS + 2;
    localparam int HALF_W         = COORD_BITS - 1;

    // rotation magnitudes: 16 fraction bits, capped at 1.0
    localparam int MAT_FRAC  = 16;
    localparam int MAT_W     = MAT_FRAC + 1;
    localparam int MAT_SHIFT = 2 * QUAT_FRAC_BITS - MAT_FRAC;

    localparam int PROD_W  = 2 * QUAT_W;
    localparam int ELEM_W  = 2 * QUAT_FRAC_BITS + 4;
    localparam int SCALE_W = HALF_W + MAT_W;
    localparam int SUM_W   = HALF_W + 2;
    localparam int BND_W   = SUM_W + 2;

    // register stages from start to done
    localparam int PIPE_LAT = 6;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] centre_x;
        logic signed [COORD_BITS-1:0] centre_y;
        logic signed [COORD_BITS-1:0] centre_z;
        logic        [HALF_W-1:0]     half_x;
        logic        [HALF_W-1:0]     half_y;
        logic        [HALF_W-1:0]     half_z;
        logic signed [QUAT_W-1:0]     quat_w;
        logic signed [QUAT_W-1:0]     quat_x;
        logic signed [QUAT_W-1:0]     quat_y;
        logic signed [QUAT_W-1:0]     quat_z;
    } box_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] min_z;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
        logic signed [COORD_BITS-1:0] max_z;
    } aabb_t;

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] centre;
        logic [2:0][HALF_W-1:0]     half;
    } side_t;

    typedef struct packed {
        side_t                      side;
        logic [2:0][2:0][MAT_W-1:0] mag;
    } mat_beat_t;

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] centre;
        logic [2:0][SUM_W-1:0]      sum;
    } ext_beat_t;

endpackage

@@ sv/obb_quat_mat.sv @@
`timescale 1ns / 1ps

module obb_quat_mat
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  obb_pkg::box_t      box,
    output logic               out_valid,
    output obb_pkg::mat_beat_t mat_beat
);
    import obb_pkg::*;

    localparam logic signed [QUAT_W-1:0] Q_ONE =
        {{(QUAT_W-QUAT_FRAC_BITS-1){1'b0}}, 1'b1, {QUAT_FRAC_BITS{1'b0}}};
    localparam logic signed [ELEM_W-1:0] E_ONE =
        {{(ELEM_W-2*QUAT_FRAC_BITS-1){1'b0}}, 1'b1, {(2*QUAT_FRAC_BITS){1'b0}}};
    localparam logic [ELEM_W:0] MAT_ONE = (ELEM_W+1)'(1) << MAT_FRAC;

    function automatic logic signed [QUAT_W-1:0] clamp_q(input logic signed [QUAT_W-1:0] v);
        logic signed [QUAT_W-1:0] r;
        r = v;
        if (v > Q_ONE)
        begin
            r = Q_ONE;
        end
        else if (v < -Q_ONE)
        begin
            r = -Q_ONE;
        end
        return r;
    endfunction

    // |v| rounded half up to MAT_FRAC bits, capped at 1.0
    function automatic logic [MAT_W-1:0] mag_of(input logic signed [ELEM_W-1:0] v);
        logic [ELEM_W-1:0] a;
        logic [ELEM_W:0]   r;
        a = v[ELEM_W-1] ? ELEM_W'(-v) : ELEM_W'(v);
        r = {a, 1'b0} >> MAT_SHIFT;
        r = (r + 1'b1) >> 1;
        return (r > MAT_ONE) ? MAT_ONE[MAT_W-1:0] : r[MAT_W-1:0];
    endfunction

    // stage a: clamped quaternion
    logic                     a_valid_reg;
    side_t                    a_side_reg;
    logic signed [QUAT_W-1:0] a_w_reg, a_x_reg, a_y_reg, a_z_reg;

    // stage b: component products
    logic                     b_valid_reg;
    side_t                    b_side_reg;
    logic signed [PROD_W-1:0] b_xx_reg, b_yy_reg, b_zz_reg;
    logic signed [PROD_W-1:0] b_xy_reg, b_xz_reg, b_yz_reg;
    logic signed [PROD_W-1:0] b_wx_reg, b_wy_reg, b_wz_reg;

    // stage c: matrix magnitudes
    logic                       c_valid_reg;
    mat_beat_t                  c_beat_reg;
    logic [2:0][2:0][MAT_W-1:0] c_mag_next;

    logic signed [ELEM_W-1:0] e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg.centre <= {box.centre_z, box.centre_y, box.centre_x};
        a_side_reg.half   <= {box.half_z, box.half_y, box.half_x};
        a_w_reg           <= clamp_q(box.quat_w);
        a_x_reg           <= clamp_q(box.quat_x);
        a_y_reg           <= clamp_q(box.quat_y);
        a_z_reg           <= clamp_q(box.quat_z);

        b_side_reg <= a_side_reg;
        b_xx_reg   <= a_x_reg * a_x_reg;
        b_yy_reg   <= a_y_reg * a_y_reg;
        b_zz_reg   <= a_z_reg * a_z_reg;
        b_xy_reg   <= a_x_reg * a_y_reg;
        b_xz_reg   <= a_x_reg * a_z_reg;
        b_yz_reg   <= a_y_reg * a_z_reg;
        b_wx_reg   <= a_w_reg * a_x_reg;
        b_wy_reg   <= a_w_reg * a_y_reg;
        b_wz_reg   <= a_w_reg * a_z_reg;

        c_beat_reg.side <= b_side_reg;
        c_beat_reg.mag  <= c_mag_next;
    end

    always_comb
    begin
        e_xx = ELEM_W'(b_xx_reg);
        e_yy = ELEM_W'(b_yy_reg);
        e_zz = ELEM_W'(b_zz_reg);
        e_xy = ELEM_W'(b_xy_reg);
        e_xz = ELEM_W'(b_xz_reg);
        e_yz = ELEM_W'(b_yz_reg);
        e_wx = ELEM_W'(b_wx_reg);
        e_wy = ELEM_W'(b_wy_reg);
        e_wz = ELEM_W'(b_wz_reg);

        c_mag_next[0][0] = mag_of(E_ONE - ((e_yy + e_zz) <<< 1));
        c_mag_next[0][1] = mag_of((e_xy - e_wz) <<< 1);
        c_mag_next[0][2] = mag_of((e_xz + e_wy) <<< 1);
        c_mag_next[1][0] = mag_of((e_xy + e_wz) <<< 1);
        c_mag_next[1][1] = mag_of(E_ONE - ((e_xx + e_zz) <<< 1));
        c_mag_next[1][2] = mag_of((e_yz - e_wx) <<< 1);
        c_mag_next[2][0] = mag_of((e_xz - e_wy) <<< 1);
        c_mag_next[2][1] = mag_of((e_yz + e_wx) <<< 1);
        c_mag_next[2][2] = mag_of(E_ONE - ((e_xx + e_yy) <<< 1));
    end

    assign out_valid = c_valid_reg;
    assign mat_beat  = c_beat_reg;

endmodule

@@ sv/obb_extent.sv @@
`timescale 1ns / 1ps

module obb_extent
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  obb_pkg::mat_beat_t mat_beat,
    output logic               out_valid,
    output obb_pkg::ext_beat_t ext_beat
);
    import obb_pkg::*;

    localparam logic [SCALE_W:0] RND_HALF = (SCALE_W+1)'(1) << (MAT_FRAC - 1);

    // stage d: |R_ij| * half_j
    logic                         d_valid_reg;
    logic [2:0][COORD_BITS-1:0]   d_centre_reg;
    logic [2:0][2:0][SCALE_W-1:0] d_prod_reg;

    // stage e: rounded per-axis sums
    logic                   e_valid_reg;
    ext_beat_t              e_beat_reg;
    logic [2:0][SUM_W-1:0]  e_sum_next;

    logic [SCALE_W:0]             rnd;
    logic [2:0][2:0][HALF_W-1:0]  term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= in_valid;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_centre_reg <= mat_beat.side.centre;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                d_prod_reg[i][j] <= SCALE_W'(mat_beat.side.half[j]) *
                                    SCALE_W'(mat_beat.mag[i][j]);
            end
        end

        e_beat_reg.centre <= d_centre_reg;
        e_beat_reg.sum    <= e_sum_next;
    end

    always_comb
    begin
        rnd = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                // round half up; a magnitude of at most 1.0 keeps it within half_j
                rnd        = (SCALE_W+1)'(d_prod_reg[i][j]) + RND_HALF;
                term[i][j] = rnd[MAT_FRAC+HALF_W-1:MAT_FRAC];
            end
            e_sum_next[i] = SUM_W'(term[i][0]) + SUM_W'(term[i][1]) + SUM_W'(term[i][2]);
        end
    end

    assign out_valid = e_valid_reg;
    assign ext_beat  = e_beat_reg;

endmodule

@@ sv/obb_bound.sv @@
`timescale 1ns / 1ps

module obb_bound
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  obb_pkg::ext_beat_t ext_beat,
    output logic               out_valid,
    output obb_pkg::aabb_t     aabb
);
    import obb_pkg::*;

    localparam logic signed [BND_W-1:0] SAT_HI = (BND_W'(1) <<< (COORD_BITS - 1)) - 1;
    localparam logic signed [BND_W-1:0] SAT_LO = -SAT_HI - 1;

    function automatic logic [COORD_BITS-1:0] sat(input logic signed [BND_W-1:0] v);
        logic signed [BND_W-1:0] r;
        r = v;
        if (v > SAT_HI)
        begin
            r = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO;
        end
        return r[COORD_BITS-1:0];
    endfunction

    logic  f_valid_reg;
    aabb_t f_aabb_reg;
    aabb_t f_aabb_next;

    logic signed [BND_W-1:0] ctr [3];
    logic signed [BND_W-1:0] ext [3];
    logic        [COORD_BITS-1:0] lo_sat [3];
    logic        [COORD_BITS-1:0] hi_sat [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ctr[i]    = BND_W'($signed(ext_beat.centre[i]));
            ext[i]    = $signed({{(BND_W-SUM_W){1'b0}}, ext_beat.sum[i]});
            lo_sat[i] = sat(ctr[i] - ext[i]);
            hi_sat[i] = sat(ctr[i] + ext[i]);
        end
        f_aabb_next.min_x = lo_sat[0];
        f_aabb_next.min_y = lo_sat[1];
        f_aabb_next.min_z = lo_sat[2];
        f_aabb_next.max_x = hi_sat[0];
        f_aabb_next.max_y = hi_sat[1];
        f_aabb_next.max_z = hi_sat[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        f_aabb_reg <= f_aabb_next;
    end

    assign out_valid = f_valid_reg;
    assign aabb      = f_aabb_reg;

endmodule

@@ sv/obb_to_aabb.sv @@
`timescale 1ns / 1ps
`include "obb_to_aabb_assert.svh"

// Oriented box to enclosing axis-aligned box. One box is taken on every clock
// (busy stays low) and its result comes out on done with aabb once it has
// passed through the six register stages; a box can follow in every cycle. The six
// register stages are quaternion clamp, the nine quaternion products, the
// rotation magnitudes, the nine extent products (31 x 17 bits), the rounded
// per-axis sums, and the saturating min/max add. The receiver cannot stall:
// each result is on the ports for one cycle only and must be taken then.
module obb_to_aabb
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  obb_pkg::box_t  box,
    output logic           done,
    output obb_pkg::aabb_t aabb
);
    import obb_pkg::*;

    logic      mat_valid;
    mat_beat_t mat_beat;
    logic      ext_valid;
    ext_beat_t ext_beat;

    assign busy = 1'b0;

    obb_quat_mat u_quat_mat
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .box       (box),
        .out_valid (mat_valid),
        .mat_beat  (mat_beat)
    );

    obb_extent u_extent
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mat_valid),
        .mat_beat  (mat_beat),
        .out_valid (ext_valid),
        .ext_beat  (ext_beat)
    );

    obb_bound u_bound
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ext_valid),
        .ext_beat  (ext_beat),
        .out_valid (done),
        .aabb      (aabb)
    );

    // every beat comes out on done, and nothing else does
    `OBB_ASSERT_DLY(a_beat_out, clk, rst_n, start && !busy, PIPE_LAT, done)
    `OBB_ASSERT_IMP(a_no_extra, clk, rst_n, done, $past(start && !busy, PIPE_LAT))
    // extents are never negative, so the box cannot invert
    `OBB_ASSERT_IMP(a_ordered, clk, rst_n, done,
                    (aabb.min_x <= aabb.max_x) && (aabb.min_y <= aabb.max_y) &&
                    (aabb.min_z <= aabb.max_z))

endmodule

@@ test/tb_obb_to_aabb.sv @@
`timescale 1ns / 1ps

module tb_obb_to_aabb;

    import obb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BOXES = 1000;
    localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam longint QUAT_ONE  = 64'sd1 <<< QUAT_FRAC_BITS;
    localparam longint MAT_ONE   = 64'sd1 <<< MAT_FRAC;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    box_t   box;
    logic   done;
    aabb_t  aabb;

    aabb_t  predicted_aabbs[$];
    int     mismatches;
    int     cycles;
    bit     no_idle;

    obb_to_aabb dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .box   (box),
        .done  (done),
        .aabb  (aabb)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic longint clamp_quat(input logic signed [QUAT_W-1:0] q);
        longint v;
        v = longint'(q);
        if (v > QUAT_ONE)
            v = QUAT_ONE;
        if (v < -QUAT_ONE)
            v = -QUAT_ONE;
        return v;
    endfunction

    // |element| rounded half up to MAT_FRAC bits, capped at 1.0
    function automatic longint rot_mag(input longint v);
        longint a;
        longint r;
        a = (v < 0) ? -v : v;
        r = (a << 1) >> MAT_SHIFT;
        r = (r + 1) >> 1;
        return (r > MAT_ONE) ? MAT_ONE : r;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_coord(input longint v);
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic aabb_t predict_aabb(input box_t b);
        longint w, x, y, z;
        longint one;
        longint c [3];
        longint h [3];
        longint e [3][3];
        longint sum;
        logic signed [COORD_BITS-1:0] lo [3];
        logic signed [COORD_BITS-1:0] hi [3];
        aabb_t r;
        w = clamp_quat(b.quat_w);
        x = clamp_quat(b.quat_x);
        y = clamp_quat(b.quat_y);
        z = clamp_quat(b.quat_z);
        one = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
        c[0] = longint'($signed(b.centre_x));
        c[1] = longint'($signed(b.centre_y));
        c[2] = longint'($signed(b.centre_z));
        h[0] = longint'(b.half_x);
        h[1] = longint'(b.half_y);
        h[2] = longint'(b.half_z);
        e[0][0] = one - 2 * (y * y + z * z);
        e[0][1] = 2 * (x * y - w * z);
        e[0][2] = 2 * (x * z + w * y);
        e[1][0] = 2 * (x * y + w * z);
        e[1][1] = one - 2 * (x * x + z * z);
        e[1][2] = 2 * (y * z - w * x);
        e[2][0] = 2 * (x * z - w * y);
        e[2][1] = 2 * (y * z + w * x);
        e[2][2] = one - 2 * (x * x + y * y);
        for (int i = 0; i < 3; i++)
        begin
            sum = 0;
            for (int j = 0; j < 3; j++)
                sum += (h[j] * rot_mag(e[i][j]) + (MAT_ONE >> 1)) >> MAT_FRAC;
            lo[i] = sat_coord(c[i] - sum);
            hi[i] = sat_coord(c[i] + sum);
        end
        r.min_x = lo[0];
        r.min_y = lo[1];
        r.min_z = lo[2];
        r.max_x = hi[0];
        r.max_y = hi[1];
        r.max_z = hi[2];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic box_t make_box(
        input logic signed [COORD_BITS-1:0] cx, cy, cz,
        input logic [HALF_W-1:0]            hx, hy, hz,
        input logic signed [QUAT_W-1:0]     qw, qx, qy, qz);
        box_t b;
        b.centre_x = cx;
        b.centre_y = cy;
        b.centre_z = cz;
        b.half_x   = hx;
        b.half_y   = hy;
        b.half_z   = hz;
        b.quat_w   = qw;
        b.quat_x   = qx;
        b.quat_y   = qy;
        b.quat_z   = qz;
        return b;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(3))
            0: return COORD_BITS'($urandom_range(2097152)) - 32'sd1048576;
            1: return 32'h7FFFFFFF - COORD_BITS'($urandom_range(1 << 20));
            2: return 32'h80000000 + COORD_BITS'($urandom_range(1 << 20));
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [HALF_W-1:0] rand_half();
        case ($urandom_range(4))
            0: return HALF_W'($urandom_range(1 << 20));
            1: return HALF_W'($urandom_range(1 << 24));
            2: return ($urandom_range(3) == 0) ? '0
                      : 31'h7FFFFFFF - HALF_W'($urandom_range(255));
            default: return HALF_W'($urandom);
        endcase
    endfunction

    // components of common axis rotations
    function automatic logic signed [QUAT_W-1:0] special_quat();
        case ($urandom_range(6))
            0: return 16'sd0;
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return 16'sd11585;
            4: return -16'sd11585;
            5: return 16'sd8192;
            default: return -16'sd8192;
        endcase
    endfunction

    // one beat, with random idle cycles ahead of it unless no_idle is set
    task automatic send_box(input box_t b);
        if (!no_idle && $urandom_range(99) < 25)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 25);
        end
        start <= 1'b1;
        box   <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted_aabbs.push_back(predict_aabb(b));
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_zero_extent();
        send_box(make_box(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
        send_box(make_box(32'h7FFFFFFF, 32'h80000000, -1, 0, 0, 0, 16384, 0, 0, 0));
        send_box(make_box(32'h12345678, -32'sd65536, 32'h00010000, 0, 0, 0,
                          11585, 0, 0, 11585));
    endtask

    task automatic test_rotations();
        logic [HALF_W-1:0] h1, h2, h3;
        h1 = 31'h00010000;
        h2 = 31'h00020000;
        h3 = 31'h00030000;
        send_box(make_box(0, 0, 0, h1, h2, h3, 11585, 0, 0, 11585));
        send_box(make_box(0, 0, 0, h1, h2, h3, 0, 16384, 0, 0));
        send_box(make_box(0, 0, 0, h1, h2, h3, 8192, 8192, 8192, 8192));
        send_box(make_box(0, 0, 0, h1, h2, h3, -16384, 0, 0, 0));
        send_box(make_box(0, 0, 0, h1, h2, h3, 11585, 0, 11585, 0));
        send_box(make_box(0, 0, 0, h1, h2, h3, 11585, -11585, 0, 0));
        send_box(make_box(0, 0, 0, h1, h2, h3, 0, 0, 0, 16384));
        send_box(make_box(32'sd1000, -32'sd1000, 32'sd77, 31'd1, 31'd3, 31'd5,
                          8192, -8192, 8192, -8192));
    endtask

    // no renormalization: components and magnitudes clamp to 1.0
    task automatic test_nonunit_quat();
        logic [HALF_W-1:0] hv;
        hv = 31'h00100000;
        send_box(make_box(0, 0, 0, hv, hv, hv, 32767, 32767, 32767, 32767));
        send_box(make_box(0, 0, 0, hv, hv, hv, -32768, -32768, -32768, -32768));
        send_box(make_box(0, 0, 0, hv, hv, hv, 16385, -16385, 0, 0));
        send_box(make_box(0, 0, 0, hv, hv, hv, 0, 0, 0, 0));
        send_box(make_box(0, 0, 0, hv, hv, hv, 32767, -32768, 32767, -32768));
    endtask

    task automatic test_saturation();
        send_box(make_box(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 16384, 0, 0, 0));
        send_box(make_box(32'h80000000, 32'h80000000, 32'h80000000,
                          31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 16384, 0, 0, 0));
        send_box(make_box(0, 32'h7FFFFFFF, 32'h80000000,
                          31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 8192, 8192, 8192, 8192));
    endtask

    task automatic test_random();
        box_t b;
        real  q [4];
        real  norm;
        int   kind;
        for (int n = 0; n < RANDOM_BOXES; n++)
        begin
            no_idle = (n >= 400 && n < 600);
            b.centre_x = rand_coord();
            b.centre_y = rand_coord();
            b.centre_z = rand_coord();
            b.half_x   = rand_half();
            b.half_y   = rand_half();
            b.half_z   = rand_half();
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                norm = 0.0;
                for (int k = 0; k < 4; k++)
                begin
                    q[k] = ($urandom_range(2000000) - 1000000.0) / 1000000.0;
                    norm += q[k] * q[k];
                end
                if (norm < 1.0e-6)
                begin
                    q[0] = 1.0;
                    norm = 1.0;
                end
                norm = $sqrt(norm);
                b.quat_w = QUAT_W'(int'(q[0] / norm * 16384.0));
                b.quat_x = QUAT_W'(int'(q[1] / norm * 16384.0));
                b.quat_y = QUAT_W'(int'(q[2] / norm * 16384.0));
                b.quat_z = QUAT_W'(int'(q[3] / norm * 16384.0));
            end
            else if (kind < 85)
            begin
                b.quat_w = special_quat();
                b.quat_x = special_quat();
                b.quat_y = special_quat();
                b.quat_z = special_quat();
            end
            else
            begin
                b.quat_w = QUAT_W'($urandom);
                b.quat_x = QUAT_W'($urandom);
                b.quat_y = QUAT_W'($urandom);
                b.quat_z = QUAT_W'($urandom);
            end
            send_box(b);
        end
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic check_field(input string name,
                               input logic signed [COORD_BITS-1:0] want,
                               input logic signed [COORD_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        aabb_t want;
        if (rst_n && done === 1'b1)
        begin
            if (predicted_aabbs.size() == 0)
            begin
                $error("result beat with no box outstanding");
                mismatches++;
            end
            else
            begin
                want = predicted_aabbs.pop_front();
                check_field("min_x", want.min_x, aabb.min_x);
                check_field("min_y", want.min_y, aabb.min_y);
                check_field("min_z", want.min_z, aabb.min_z);
                check_field("max_x", want.max_x, aabb.max_x);
                check_field("max_y", want.max_y, aabb.max_y);
                check_field("max_z", want.max_z, aabb.max_z);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        box        = '0;
        mismatches = 0;
        cycles     = 0;
        no_idle    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_extent();
        test_rotations();
        test_nonunit_quat();
        test_saturation();
        test_random();

        start <= 1'b0;
        while (predicted_aabbs.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
